// ===== hdl/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Types, register indexes, status and datapath op codes for the selector.
// ----------------------------------------------------------------------------
package lps_pkg;

  // register map, word index
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_RSSI_GAIN   = 3'd0;
  localparam logic [2:0] REG_SNR_GAIN    = 3'd1;
  localparam logic [2:0] REG_SMOOTH_RISE = 3'd2;
  localparam logic [2:0] REG_SMOOTH_FALL = 3'd3;
  localparam logic [2:0] REG_HYST_RISE   = 3'd4;
  localparam logic [2:0] REG_HYST_FALL   = 3'd5;
  localparam logic [2:0] REG_MIN_GAP_MS  = 3'd6;
  localparam logic [2:0] REG_HOLD_UP_MS  = 3'd7;

  // result status codes
  localparam logic [2:0] ST_APPLIED  = 3'd0;
  localparam logic [2:0] ST_ENTRY    = 3'd1;
  localparam logic [2:0] ST_GAP      = 3'd2;
  localparam logic [2:0] ST_HYST     = 3'd3;
  localparam logic [2:0] ST_NO_MATCH = 3'd4;
  localparam logic [2:0] ST_SAME     = 3'd5;
  localparam logic [2:0] ST_FB_HOLD  = 3'd6;
  localparam logic [2:0] ST_UP_HOLD  = 3'd7;

  // datapath op codes
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_CAPTURE   = 4'd1;
  localparam logic [3:0] OP_WRITE     = 4'd2;
  localparam logic [3:0] OP_SCAN_INIT = 4'd3;
  localparam logic [3:0] OP_MUL1      = 4'd4;
  localparam logic [3:0] OP_MUL2      = 4'd5;
  localparam logic [3:0] OP_SM1       = 4'd6;
  localparam logic [3:0] OP_SM2       = 4'd7;
  localparam logic [3:0] OP_EVAL      = 4'd8;
  localparam logic [3:0] OP_RES_GAP   = 4'd9;
  localparam logic [3:0] OP_HY1       = 4'd10;
  localparam logic [3:0] OP_HY2       = 4'd11;
  localparam logic [3:0] OP_RES_HYST  = 4'd12;
  localparam logic [3:0] OP_SCAN      = 4'd13;
  localparam logic [3:0] OP_PUSH      = 4'd14;

  localparam logic [27:0] SMOOTH_RESET = 28'(1500) << 16;
  localparam logic [27:0] SMOOTH_MAX   = 28'hFFF_FFFF;
  localparam logic [11:0] LAST_RESET   = 12'd100;
  localparam logic [14:0] PCT_SCALE    = 15'd25600;

  typedef struct packed {
    logic        cmd;
    logic [11:0] rssi_in;
    logic [11:0] snr_in;
    logic [31:0] now_ms;
    logic [3:0]  entry_index;
    logic [11:0] entry_min;
    logic [11:0] entry_max;
  } in_t;

  typedef struct packed {
    logic        applied;
    logic [2:0]  status;
    logic [3:0]  profile_index;
    logic [11:0] smoothed_score;
    logic [15:0] raw_score;
  } out_t;

  typedef struct packed {
    logic [15:0] rssi_gain;
    logic [15:0] snr_gain;
    logic [15:0] smooth_rise;
    logic [15:0] smooth_fall;
    logic [15:0] hyst_rise;
    logic [15:0] hyst_fall;
    logic [15:0] min_gap_ms;
    logic [31:0] hold_up_ms;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
  } ctl_t;

  typedef struct packed {
    logic is_load;
    logic is_fallback;
    logic gap;
    logic hyst_ok;
    logic scan_match;
    logic scan_last;
  } sts_t;

endpackage

// ===== hdl/lps_regs.sv =====
// ----------------------------------------------------------------------------
// lps_regs
// APB-style configuration register file.
// ----------------------------------------------------------------------------
module lps_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lps_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output lps_pkg::cfg_t              cfg
);

  logic wr;
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rssi_gain   <= 16'd8192;
      cfg.snr_gain    <= 16'd8192;
      cfg.smooth_rise <= 16'd32768;
      cfg.smooth_fall <= 16'd32768;
      cfg.hyst_rise   <= 16'd1280;
      cfg.hyst_fall   <= 16'd1280;
      cfg.min_gap_ms  <= 16'd200;
      cfg.hold_up_ms  <= 32'd3000;
    end else if (wr) begin
      unique case (paddr[4:2])
        lps_pkg::REG_RSSI_GAIN:   cfg.rssi_gain   <= pwdata[15:0];
        lps_pkg::REG_SNR_GAIN:    cfg.snr_gain    <= pwdata[15:0];
        lps_pkg::REG_SMOOTH_RISE: cfg.smooth_rise <= pwdata[15:0];
        lps_pkg::REG_SMOOTH_FALL: cfg.smooth_fall <= pwdata[15:0];
        lps_pkg::REG_HYST_RISE:   cfg.hyst_rise   <= pwdata[15:0];
        lps_pkg::REG_HYST_FALL:   cfg.hyst_fall   <= pwdata[15:0];
        lps_pkg::REG_MIN_GAP_MS:  cfg.min_gap_ms  <= pwdata[15:0];
        lps_pkg::REG_HOLD_UP_MS:  cfg.hold_up_ms  <= pwdata;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[4:2])
      lps_pkg::REG_RSSI_GAIN:   prdata = {16'd0, cfg.rssi_gain};
      lps_pkg::REG_SNR_GAIN:    prdata = {16'd0, cfg.snr_gain};
      lps_pkg::REG_SMOOTH_RISE: prdata = {16'd0, cfg.smooth_rise};
      lps_pkg::REG_SMOOTH_FALL: prdata = {16'd0, cfg.smooth_fall};
      lps_pkg::REG_HYST_RISE:   prdata = {16'd0, cfg.hyst_rise};
      lps_pkg::REG_HYST_FALL:   prdata = {16'd0, cfg.hyst_fall};
      lps_pkg::REG_MIN_GAP_MS:  prdata = {16'd0, cfg.min_gap_ms};
      lps_pkg::REG_HOLD_UP_MS:  prdata = cfg.hold_up_ms;
    endcase
  end

endmodule

// ===== hdl/lps_ctrl.sv =====
// ----------------------------------------------------------------------------
// lps_ctrl
// Sequencer: steps the datapath through one word and owns both handshakes.
// ----------------------------------------------------------------------------
module lps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           sample_valid,
  output logic           sample_ready,
  output logic           result_valid,
  input  logic           result_ready,
  input  lps_pkg::sts_t  sts,
  output lps_pkg::ctl_t  ctl
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_MUL2     = 4'd2;
  localparam logic [3:0] S_SM1      = 4'd3;
  localparam logic [3:0] S_SM2      = 4'd4;
  localparam logic [3:0] S_EVAL     = 4'd5;
  localparam logic [3:0] S_GAPCHK   = 4'd6;
  localparam logic [3:0] S_HY2      = 4'd7;
  localparam logic [3:0] S_HYCHK    = 4'd8;
  localparam logic [3:0] S_SCAN     = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  logic [3:0] state, state_next;
  logic       out_free;

  assign sample_ready = (state == S_IDLE);
  assign out_free     = !result_valid || result_ready;

  // next state and op
  always_comb begin
    state_next = state;
    ctl.op     = lps_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          ctl.op     = lps_pkg::OP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_load) begin
          ctl.op     = lps_pkg::OP_WRITE;
          state_next = S_OUT;
        end else if (sts.is_fallback) begin
          ctl.op     = lps_pkg::OP_SCAN_INIT;
          state_next = S_SCAN;
        end else begin
          ctl.op     = lps_pkg::OP_MUL1;
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        ctl.op     = lps_pkg::OP_MUL2;
        state_next = S_SM1;
      end
      S_SM1: begin
        ctl.op     = lps_pkg::OP_SM1;
        state_next = S_SM2;
      end
      S_SM2: begin
        ctl.op     = lps_pkg::OP_SM2;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        ctl.op     = lps_pkg::OP_EVAL;
        state_next = S_GAPCHK;
      end
      S_GAPCHK: begin
        if (sts.gap) begin
          ctl.op     = lps_pkg::OP_RES_GAP;
          state_next = S_OUT;
        end else begin
          ctl.op     = lps_pkg::OP_HY1;
          state_next = S_HY2;
        end
      end
      S_HY2: begin
        ctl.op     = lps_pkg::OP_HY2;
        state_next = S_HYCHK;
      end
      S_HYCHK: begin
        if (sts.hyst_ok) begin
          ctl.op     = lps_pkg::OP_SCAN_INIT;
          state_next = S_SCAN;
        end else begin
          ctl.op     = lps_pkg::OP_RES_HYST;
          state_next = S_OUT;
        end
      end
      S_SCAN: begin
        ctl.op = lps_pkg::OP_SCAN;
        if (sts.scan_match || sts.scan_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ctl.op     = lps_pkg::OP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.op == lps_pkg::OP_PUSH) result_valid <= 1'b1;
      else if (result_ready)          result_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/lps_dp.sv =====
// ----------------------------------------------------------------------------
// lps_dp
// Datapath: weighting, smoothing, hysteresis, range scan and hold decisions.
// ----------------------------------------------------------------------------
module lps_dp #(
  parameter int NUM_PROFILES     = 16,
  parameter int SCORE_BASE       = 1000,
  parameter int SCORE_TOP        = 2000,
  parameter int FALLBACK_VALUE   = 999,
  parameter int HOLD_FALLBACK_MS = 1000,
  parameter int SCORE_CAP        = 2000
) (
  input  logic           clk,
  input  logic           rst,
  input  lps_pkg::in_t   sample,
  input  lps_pkg::cfg_t  cfg,
  input  lps_pkg::ctl_t  ctl,
  output lps_pkg::sts_t  sts,
  output lps_pkg::out_t  result
);

  localparam int IW = (NUM_PROFILES > 1) ? $clog2(NUM_PROFILES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_PROFILES - 1);
  localparam logic [11:0] BASE_V = 12'(SCORE_BASE);
  localparam logic [11:0] TOP_V  = 12'(SCORE_TOP);
  localparam logic [11:0] FB_V   = 12'(FALLBACK_VALUE);
  localparam logic [31:0] HOLD_FB = 32'(HOLD_FALLBACK_MS);
  localparam logic [28:0] CAP_Q  = 29'(SCORE_CAP) << 14;
  localparam logic        CAP_ON = (SCORE_CAP < SCORE_TOP);

  logic [11:0]   lo_tab [NUM_PROFILES];
  logic [11:0]   hi_tab [NUM_PROFILES];
  logic [27:0]   smoothed;
  logic [11:0]   last_sent;
  logic [31:0]   last_change;
  logic          prior_valid;
  logic [IW-1:0] prior_idx;

  lps_pkg::in_t  item;
  logic [27:0]   prod;
  logic [28:0]   sum;
  logic [46:0]   pa;
  logic [15:0]   fr;
  logic [11:0]   v;
  logic [11:0]   diff;
  logic [15:0]   thr;
  logic          gap;
  logic          hyst_ok;
  logic [IW-1:0] scan_idx;
  logic [2:0]    res_status;
  logic [3:0]    res_idx;
  logic [15:0]   raw;

  logic [28:0]   capped;
  logic [30:0]   comb;
  logic [47:0]   acc;
  logic [31:0]   acc_int;
  logic [31:0]   elapsed;
  logic [11:0]   sm_int;
  logic [11:0]   v_clamp;
  logic          hit;
  logic [2:0]    dec_status;

  // combinational helpers
  always_comb begin
    capped  = (CAP_ON && (sum > CAP_Q)) ? CAP_Q : sum;
    comb    = {capped, 2'b00};
    acc     = {1'b0, pa} + 48'((17'h10000 - {1'b0, fr}) * smoothed);
    acc_int = acc[47:16];
    elapsed = item.now_ms - last_change;
    sm_int  = smoothed[27:16];
    if (sm_int < BASE_V)     v_clamp = BASE_V;
    else if (sm_int > TOP_V) v_clamp = TOP_V;
    else                     v_clamp = sm_int;
    hit = (v >= lo_tab[scan_idx]) && (v <= hi_tab[scan_idx]);
  end

  // hold decision for the entry under test
  always_comb begin
    priority if (prior_valid && (prior_idx == scan_idx)) begin
      dec_status = lps_pkg::ST_SAME;
    end else if (prior_valid && (prior_idx == '0)) begin
      dec_status = (elapsed <= HOLD_FB) ? lps_pkg::ST_FB_HOLD : lps_pkg::ST_APPLIED;
    end else if ((!prior_valid || (prior_idx < scan_idx)) && (elapsed <= cfg.hold_up_ms)) begin
      dec_status = lps_pkg::ST_UP_HOLD;
    end else begin
      dec_status = lps_pkg::ST_APPLIED;
    end
  end

  assign sts.is_load     = item.cmd;
  assign sts.is_fallback = (item.rssi_in == FB_V);
  assign sts.gap         = gap;
  assign sts.hyst_ok     = hyst_ok;
  assign sts.scan_match  = hit;
  assign sts.scan_last   = (scan_idx == LAST_IDX);

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PROFILES; i++) begin
        lo_tab[i] <= '0;
        hi_tab[i] <= '0;
      end
      smoothed    <= lps_pkg::SMOOTH_RESET;
      last_sent   <= lps_pkg::LAST_RESET;
      last_change <= '0;
      prior_valid <= 1'b0;
      prior_idx   <= '0;
    end else begin
      if ((ctl.op == lps_pkg::OP_WRITE) && (32'(item.entry_index) < 32'(NUM_PROFILES))) begin
        lo_tab[IW'(item.entry_index)] <= item.entry_min;
        hi_tab[IW'(item.entry_index)] <= item.entry_max;
      end
      if (ctl.op == lps_pkg::OP_SM2) begin
        smoothed <= (acc_int > 32'(lps_pkg::SMOOTH_MAX)) ? lps_pkg::SMOOTH_MAX
                                                          : acc_int[27:0];
      end
      if ((ctl.op == lps_pkg::OP_SCAN) && hit && (dec_status == lps_pkg::ST_APPLIED)) begin
        prior_valid <= 1'b1;
        prior_idx   <= scan_idx;
        last_change <= item.now_ms;
        last_sent   <= v;
        if (sts.is_fallback) smoothed <= {FB_V, 16'd0};
      end
    end
  end

  // per-word working registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      lps_pkg::OP_CAPTURE: begin
        item <= sample;
        v    <= FB_V;
        raw  <= '0;
      end
      lps_pkg::OP_WRITE: begin
        res_status <= lps_pkg::ST_ENTRY;
        res_idx    <= item.entry_index;
      end
      lps_pkg::OP_SCAN_INIT: scan_idx <= '0;
      lps_pkg::OP_MUL1: prod <= item.rssi_in * cfg.rssi_gain;
      lps_pkg::OP_MUL2: sum <= {1'b0, prod} + 29'(item.snr_in * cfg.snr_gain);
      lps_pkg::OP_SM1: begin
        raw <= 16'(sum[28:14]);
        fr  <= (capped >= ({17'd0, last_sent} << 14)) ? cfg.smooth_rise : cfg.smooth_fall;
        pa  <= 47'(((capped >= ({17'd0, last_sent} << 14)) ? cfg.smooth_rise
                                                            : cfg.smooth_fall) * comb);
      end
      lps_pkg::OP_SM2: ;
      lps_pkg::OP_EVAL: begin
        gap  <= elapsed < {16'd0, cfg.min_gap_ms};
        v    <= v_clamp;
        diff <= (v_clamp >= last_sent) ? v_clamp - last_sent : last_sent - v_clamp;
        thr  <= (v_clamp >= last_sent) ? cfg.hyst_rise : cfg.hyst_fall;
      end
      lps_pkg::OP_RES_GAP: begin
        res_status <= lps_pkg::ST_GAP;
        res_idx    <= '0;
      end
      lps_pkg::OP_HY1: pa <= 47'(diff * lps_pkg::PCT_SCALE);
      lps_pkg::OP_HY2: begin
        hyst_ok <= (pa >= 47'(thr * last_sent)) && !((last_sent == '0) && (diff == '0));
      end
      lps_pkg::OP_RES_HYST: begin
        res_status <= lps_pkg::ST_HYST;
        res_idx    <= '0;
      end
      lps_pkg::OP_SCAN: begin
        if (hit) begin
          res_status <= dec_status;
          res_idx    <= 4'(scan_idx);
        end else if (scan_idx == LAST_IDX) begin
          res_status <= lps_pkg::ST_NO_MATCH;
          res_idx    <= '0;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      lps_pkg::OP_PUSH: begin
        result.applied        <= (res_status == lps_pkg::ST_APPLIED);
        result.status         <= res_status;
        result.profile_index  <= res_idx;
        result.smoothed_score <= smoothed[27:16];
        result.raw_score      <= raw;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/link_profile_selector_top.sv =====
// ----------------------------------------------------------------------------
// link_profile_selector_top: one word at a time. Load: DISPATCH, OUT. Fallback:
// DISPATCH, SCAN, OUT. Sample: DISPATCH, MUL2, SM1, SM2, EVAL, GAPCHK, then OUT on a
// gap, else HY2, HYCHK, then OUT on a hysteresis reject, else SCAN (one range per
// cycle), OUT; a stalled output holds OUT. Next word is taken the cycle after the
// result is registered. Reset (sync, high) clears range table, smoothing, selection.
// ----------------------------------------------------------------------------
module link_profile_selector_top #(
  parameter int NUM_PROFILES     = 16,
  parameter int SCORE_BASE       = 1000,
  parameter int SCORE_TOP        = 2000,
  parameter int FALLBACK_VALUE   = 999,
  parameter int HOLD_FALLBACK_MS = 1000,
  parameter int SCORE_CAP        = 2000
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  lps_pkg::in_t               sample,
  output logic                       result_valid,
  input  logic                       result_ready,
  output lps_pkg::out_t              result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lps_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  lps_pkg::cfg_t cfg;
  lps_pkg::ctl_t ctl;
  lps_pkg::sts_t sts;

  lps_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  lps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .sample_valid(sample_valid), .sample_ready(sample_ready),
    .result_valid(result_valid), .result_ready(result_ready), .sts(sts), .ctl(ctl)
  );

  lps_dp #(
    .NUM_PROFILES(NUM_PROFILES), .SCORE_BASE(SCORE_BASE), .SCORE_TOP(SCORE_TOP),
    .FALLBACK_VALUE(FALLBACK_VALUE), .HOLD_FALLBACK_MS(HOLD_FALLBACK_MS),
    .SCORE_CAP(SCORE_CAP)
  ) u_dp (
    .clk(clk), .rst(rst), .sample(sample), .cfg(cfg), .ctl(ctl), .sts(sts),
    .result(result)
  );

`ifndef SYNTHESIS
  // busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("accepted a second word back to back");

  // the output register is loaded only when free
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == lps_pkg::OP_PUSH) |-> (!result_valid || result_ready))
    else $error("result overwritten before it was taken");

  // applied flag tracks status
  a_applied: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.applied == (result.status == lps_pkg::ST_APPLIED)))
    else $error("applied flag disagrees with status");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: link profile selector testbench
// Loads range tables, sweeps register settings (reset values, zero, full scale,
// random) and drives sample, fallback and load words with random gaps and
// result stalls. Each result is checked against an in-bench selection model or a typed row's word.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          N_PROF      = 16;
  localparam int          BASE_SCORE  = 1000;
  localparam int          TOP_SCORE   = 2000;
  localparam logic [11:0] FB_SCORE    = 12'd999;
  localparam int          FB_HOLD_MS  = 1000;
  localparam int          CAP_SCORE   = 2000;
  localparam int          SETTLE_CYC  = 40;
  localparam int          STALL_LIMIT = 5000;
  localparam int          RAND_WORDS  = 1840;
  localparam int          N_PHASES    = 6;

  logic          clk;
  logic          rst;
  logic          sample_valid;
  logic          sample_ready;
  lps_pkg::in_t  sample;
  logic          result_valid;
  logic          result_ready;
  lps_pkg::out_t result;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [lps_pkg::ADDR_W-1:0] paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  link_profile_selector_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // selection model state
  lps_pkg::cfg_t cfg_shadow;
  logic [11:0]   lo_tab [N_PROF];
  logic [11:0]   hi_tab [N_PROF];
  logic [27:0]   sm_val;
  logic [11:0]   last_val;
  logic [31:0]   change_ms;
  int            prior_prof;

  lps_pkg::out_t expected_results[$];
  int   errors;
  int   words_sent;
  int   status_count [8];
  bit   gaps_on;
  bit   long_hold_req;
  int   idle_cycles;

  // range lookup and hold rules; updates selection state on apply
  function automatic logic [2:0] pick_profile(input logic [11:0] v, input logic [31:0] now,
                                              output logic [3:0] idx);
    int          hit;
    logic [31:0] el;
    hit = -1;
    idx = '0;
    for (int i = 0; i < N_PROF; i++) begin
      if (hit < 0 && v >= lo_tab[i] && v <= hi_tab[i]) hit = i;
    end
    if (hit < 0) return lps_pkg::ST_NO_MATCH;
    idx = hit[3:0];
    if (prior_prof == hit) return lps_pkg::ST_SAME;
    el = now - change_ms;
    if (prior_prof == 0) begin
      if (el <= 32'(FB_HOLD_MS)) return lps_pkg::ST_FB_HOLD;
    end else if (prior_prof < hit && el <= cfg_shadow.hold_up_ms) begin
      return lps_pkg::ST_UP_HOLD;
    end
    prior_prof = hit;
    change_ms  = now;
    return lps_pkg::ST_APPLIED;
  endfunction

  // expected result word for one accepted input word
  function automatic lps_pkg::out_t predict_selection(input lps_pkg::in_t w);
    lps_pkg::out_t o;
    logic [2:0]  st;
    logic [3:0]  idx;
    logic [15:0] raw;
    logic [63:0] sum, comb, f, acc, r, diff, thr, lastv;
    logic [31:0] el;
    logic [11:0] v;
    idx = '0;
    raw = '0;
    if (w.cmd) begin
      lo_tab[w.entry_index] = w.entry_min;
      hi_tab[w.entry_index] = w.entry_max;
      st  = lps_pkg::ST_ENTRY;
      idx = w.entry_index;
    end else if (w.rssi_in == FB_SCORE) begin
      st = pick_profile(FB_SCORE, w.now_ms, idx);
      if (st == lps_pkg::ST_APPLIED) begin
        last_val = FB_SCORE;
        sm_val   = {FB_SCORE, 16'h0};
      end
    end else begin
      sum = 64'(w.rssi_in) * cfg_shadow.rssi_gain + 64'(w.snr_in) * cfg_shadow.snr_gain;
      r   = sum >> 14;
      raw = (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
      if (CAP_SCORE < TOP_SCORE && sum > (64'(CAP_SCORE) << 14)) sum = 64'(CAP_SCORE) << 14;
      comb = sum << 2;
      f    = (sum >= (64'(last_val) << 14)) ? 64'(cfg_shadow.smooth_rise)
                                             : 64'(cfg_shadow.smooth_fall);
      acc  = (f * comb + (64'd65536 - f) * 64'(sm_val)) >> 16;
      sm_val = (acc > 64'(lps_pkg::SMOOTH_MAX)) ? lps_pkg::SMOOTH_MAX : acc[27:0];
      el = w.now_ms - change_ms;
      if (el < 32'(cfg_shadow.min_gap_ms)) begin
        st = lps_pkg::ST_GAP;
      end else begin
        v = sm_val[27:16];
        if (v < 12'(BASE_SCORE)) v = 12'(BASE_SCORE);
        else if (v > 12'(TOP_SCORE)) v = 12'(TOP_SCORE);
        lastv = 64'(last_val);
        diff  = (64'(v) >= lastv) ? 64'(v) - lastv : lastv - 64'(v);
        thr   = (64'(v) >= lastv) ? 64'(cfg_shadow.hyst_rise) : 64'(cfg_shadow.hyst_fall);
        if (lastv == 0 && diff == 0) begin
          st = lps_pkg::ST_HYST;
        end else if (diff * 64'd25600 >= thr * lastv) begin
          st = pick_profile(v, w.now_ms, idx);
          if (st == lps_pkg::ST_APPLIED) last_val = v;
        end else begin
          st = lps_pkg::ST_HYST;
        end
      end
    end
    o.applied        = (st == lps_pkg::ST_APPLIED);
    o.status         = st;
    o.profile_index  = idx;
    o.smoothed_score = sm_val[27:16];
    o.raw_score      = raw;
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    lps_pkg::out_t exp_word;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, result);
        errors++;
      end else begin
        exp_word = expected_results.pop_front();
        status_count[result.status]++;
        if (result.applied !== exp_word.applied) begin
          $display("%0t: applied exp %0d got %0d", $time, exp_word.applied, result.applied);
          errors++;
        end
        if (result.status !== exp_word.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_word.status, result.status);
          errors++;
        end
        if (result.profile_index !== exp_word.profile_index) begin
          $display("%0t: profile_index exp %0d got %0d", $time, exp_word.profile_index,
                   result.profile_index);
          errors++;
        end
        if (result.smoothed_score !== exp_word.smoothed_score) begin
          $display("%0t: smoothed_score exp %0d got %0d", $time, exp_word.smoothed_score,
                   result.smoothed_score);
          errors++;
        end
        if (result.raw_score !== exp_word.raw_score) begin
          $display("%0t: raw_score exp %0d got %0d", $time, exp_word.raw_score,
                   result.raw_score);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no handshake on any port
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no progress", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    result_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      n = gaps_on ? $urandom_range(0, 9) : 0;
      if (n > 0) begin
        result_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  // config write, setup then access
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lps_pkg::ADDR_W'(idx) << 2;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      lps_pkg::REG_RSSI_GAIN:   cfg_shadow.rssi_gain   = data[15:0];
      lps_pkg::REG_SNR_GAIN:    cfg_shadow.snr_gain    = data[15:0];
      lps_pkg::REG_SMOOTH_RISE: cfg_shadow.smooth_rise = data[15:0];
      lps_pkg::REG_SMOOTH_FALL: cfg_shadow.smooth_fall = data[15:0];
      lps_pkg::REG_HYST_RISE:   cfg_shadow.hyst_rise   = data[15:0];
      lps_pkg::REG_HYST_FALL:   cfg_shadow.hyst_fall   = data[15:0];
      lps_pkg::REG_MIN_GAP_MS:  cfg_shadow.min_gap_ms  = data[15:0];
      lps_pkg::REG_HOLD_UP_MS:  cfg_shadow.hold_up_ms  = data;
      default: ;
    endcase
  endtask

  // offer one word, predict on acceptance; valid stays high for back-to-back
  task automatic send_word(input lps_pkg::in_t w);
    int n;
    n = gaps_on ? $urandom_range(0, 9) : 0;
    if (n > 0) begin
      sample_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= w;
    do @(posedge clk); while (!sample_ready);
    expected_results.push_back(predict_selection(w));
    words_sent++;
  endtask

  // stop offering and wait until every result is back and the block is quiet
  task automatic drain;
    sample_valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic lps_pkg::in_t load_word(input logic [3:0] e, input logic [11:0] lo,
                                             input logic [11:0] hi);
    lps_pkg::in_t w;
    w             = '0;
    w.cmd         = 1'b1;
    w.entry_index = e;
    w.entry_min   = lo;
    w.entry_max   = hi;
    w.rssi_in     = 12'($urandom);
    w.snr_in      = 12'($urandom);
    w.now_ms      = $urandom;
    return w;
  endfunction

  function automatic lps_pkg::in_t score_word(input logic [11:0] rssi, input logic [11:0] snr,
                                              input logic [31:0] now);
    lps_pkg::in_t w;
    w             = '0;
    w.rssi_in     = rssi;
    w.snr_in      = snr;
    w.now_ms      = now;
    w.entry_index = 4'($urandom);
    w.entry_min   = 12'($urandom);
    w.entry_max   = 12'($urandom);
    return w;
  endfunction

  typedef struct {
    lps_pkg::in_t  w;
    bit            typed;
    lps_pkg::out_t exp_word;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic add_row(input lps_pkg::in_t w, input bit typed, input lps_pkg::out_t e);
    stim_row_t row;
    row.w        = w;
    row.typed    = typed;
    row.exp_word = e;
    directed.push_back(row);
  endtask

  // well-formed table: ascending ranges spread over the score span
  task automatic load_table;
    int lo, hi;
    lo = $urandom_range(900, 1050);
    for (int i = 0; i < N_PROF; i++) begin
      hi = lo + $urandom_range(30, 110);
      send_word(load_word(4'(i), 12'(lo), 12'(hi)));
      lo = hi + $urandom_range(0, 8);
    end
  endtask

  task automatic write_config(input lps_pkg::cfg_t c);
    apb_write(lps_pkg::REG_RSSI_GAIN,   32'(c.rssi_gain));
    apb_write(lps_pkg::REG_SNR_GAIN,    32'(c.snr_gain));
    apb_write(lps_pkg::REG_SMOOTH_RISE, 32'(c.smooth_rise));
    apb_write(lps_pkg::REG_SMOOTH_FALL, 32'(c.smooth_fall));
    apb_write(lps_pkg::REG_HYST_RISE,   32'(c.hyst_rise));
    apb_write(lps_pkg::REG_HYST_FALL,   32'(c.hyst_fall));
    apb_write(lps_pkg::REG_MIN_GAP_MS,  32'(c.min_gap_ms));
    apb_write(lps_pkg::REG_HOLD_UP_MS,  c.hold_up_ms);
  endtask

  // main sequence
  initial begin
    lps_pkg::cfg_t c;
    lps_pkg::in_t  w;
    logic [31:0]   now;
    int            per_phase, target, pick, sent_phase;
    errors        = 0;
    words_sent    = 0;
    gaps_on       = 1'b0;
    long_hold_req = 1'b0;
    foreach (status_count[i]) status_count[i] = 0;
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cfg_shadow = '{rssi_gain: 16'd8192, snr_gain: 16'd8192, smooth_rise: 16'd32768,
                   smooth_fall: 16'd32768, hyst_rise: 16'd1280, hyst_fall: 16'd1280,
                   min_gap_ms: 16'd200, hold_up_ms: 32'd3000};
    foreach (lo_tab[i]) begin
      lo_tab[i] = '0;
      hi_tab[i] = '0;
    end
    sm_val     = lps_pkg::SMOOTH_RESET;
    last_val   = lps_pkg::LAST_RESET;
    change_ms  = '0;
    prior_prof = -2;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset settings
    add_row(load_word(4'd0, 12'd1000, 12'd1299), 1'b1,
            '{1'b0, lps_pkg::ST_ENTRY, 4'd0, 12'd1500, 16'd0});
    add_row(load_word(4'd1, 12'd1300, 12'd1699), 1'b1,
            '{1'b0, lps_pkg::ST_ENTRY, 4'd1, 12'd1500, 16'd0});
    add_row(load_word(4'd2, 12'd1700, 12'd2000), 1'b1,
            '{1'b0, lps_pkg::ST_ENTRY, 4'd2, 12'd1500, 16'd0});
    add_row(load_word(4'd15, 12'd4095, 12'd4095), 1'b1,
            '{1'b0, lps_pkg::ST_ENTRY, 4'd15, 12'd1500, 16'd0});
    add_row(load_word(4'd14, 12'd4095, 12'd0), 1'b1,
            '{1'b0, lps_pkg::ST_ENTRY, 4'd14, 12'd1500, 16'd0});
    // zero scores inside the gap: falls halfway, no selection
    add_row(score_word(12'd0, 12'd0, 32'd100), 1'b1,
            '{1'b0, lps_pkg::ST_GAP, 4'd0, 12'd750, 16'd0});
    add_row(score_word(12'd4095, 12'd4095, 32'd5000), 1'b0, '0);
    add_row(score_word(12'd1500, 12'd1500, 32'd9000), 1'b0, '0);
    add_row(score_word(FB_SCORE, 12'd4095, 32'd9001), 1'b0, '0);
    add_row(score_word(FB_SCORE, 12'd0, 32'd12000), 1'b0, '0);
    add_row(score_word(12'd1200, 12'd1200, 32'd12050), 1'b0, '0);
    add_row(score_word(12'd1800, 12'd1900, 32'd13500), 1'b0, '0);
    add_row(score_word(12'd1800, 12'd1900, 32'd20000), 1'b0, '0);
    add_row(score_word(12'd1850, 12'd1850, 32'd21000), 1'b0, '0);
    add_row(score_word(12'd4094, 12'd1, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(score_word(12'd1000, 12'd1000, 32'd400), 1'b0, '0);
    add_row(score_word(12'd0, 12'd4095, 32'd5000), 1'b0, '0);
    foreach (directed[i]) begin
      if (directed[i].typed) begin
        send_word(directed[i].w);
        void'(expected_results.pop_back());
        expected_results.push_back(directed[i].exp_word);
      end else begin
        send_word(directed[i].w);
      end
    end
    drain();

    // random phases over several register settings
    per_phase = RAND_WORDS / N_PHASES;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: c = cfg_shadow;
        1: c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0};
        2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 32'hFFFF_FFFF};
        5: c = '{16'd8192, 16'd8192, 16'd32768, 16'd32768, 16'd1280, 16'd1280, 16'd200,
                 32'd3000};
        default: begin
          c.rssi_gain   = 16'($urandom_range(2000, 14000));
          c.snr_gain    = 16'($urandom_range(2000, 14000));
          c.smooth_rise = 16'($urandom);
          c.smooth_fall = 16'($urandom);
          c.hyst_rise   = 16'($urandom_range(0, 4000));
          c.hyst_fall   = 16'($urandom_range(0, 4000));
          c.min_gap_ms  = 16'($urandom_range(0, 600));
          c.hold_up_ms  = $urandom_range(0, 5000);
        end
      endcase
      if (ph > 0) write_config(c);
      gaps_on = (ph % 3 != 1);
      now = $urandom;
      load_table();
      sent_phase = 0;
      while (sent_phase < per_phase) begin
        if (ph == 3 && sent_phase == 40) long_hold_req = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          w = load_word(4'($urandom), 12'($urandom), 12'($urandom));
        end else begin
          case ($urandom_range(0, 9))
            0: now = now + $urandom;
            1, 2: now = now + $urandom_range(0, 5000);
            default: now = now + $urandom_range(0, 600);
          endcase
          if (pick < 12) begin
            w = score_word(FB_SCORE, 12'($urandom), now);
          end else if (pick < 20) begin
            w = score_word(12'($urandom), 12'($urandom), now);
          end else begin
            target = $urandom_range(850, 2150);
            w = score_word(12'(target + $urandom_range(0, 200) - 100),
                           12'(target + $urandom_range(0, 200) - 100), now);
            if (w.rssi_in == FB_SCORE) w.rssi_in = FB_SCORE + 12'd1;
          end
        end
        send_word(w);
        sent_phase++;
      end
      // sender pause until every result is back
      drain();
    end

    $display("Sent %0d words over %0d register settings plus directed rows.",
             words_sent, N_PHASES);
    $display("Status mix: app %0d ent %0d gap %0d hyst %0d nomatch %0d same %0d fb %0d up %0d",
             status_count[0], status_count[1], status_count[2], status_count[3],
             status_count[4], status_count[5], status_count[6], status_count[7]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
